FILE: rtl/arprp_pkg.sv
// Package: constants, status codes and result type for the ARP reply parser.
`default_nettype none
package arprp_pkg;

	localparam int PosW = 6;

	localparam logic [PosW-1:0] POS_HDR_START = PosW'(12);
	localparam logic [PosW-1:0] POS_ETH_END   = PosW'(14);
	localparam logic [PosW-1:0] POS_ARP_END   = PosW'(22);
	localparam logic [PosW-1:0] POS_MAC_END   = PosW'(28);
	localparam logic [PosW-1:0] POS_LIMIT     = PosW'(32);

	typedef logic [2:0] status_t;

	localparam status_t ST_LEARNED  = 3'd0;
	localparam status_t ST_RUNT     = 3'd1;
	localparam status_t ST_NOT_ARP  = 3'd2;
	localparam status_t ST_SHORT    = 3'd3;
	localparam status_t ST_MISMATCH = 3'd4;
	localparam status_t ST_TRUNC    = 3'd5;

	typedef struct packed {
		status_t     status;
		logic [47:0] mac;
		logic [31:0] ip;
	} result_t;

	// expected value of frame bytes 12..21, indexed from byte 12
	function automatic logic [7:0] expect_byte(input logic [3:0] idx);
		logic [7:0] val;
		case (idx)
			4'd0:    val = 8'h08;
			4'd1:    val = 8'h06;
			4'd2:    val = 8'h00;
			4'd3:    val = 8'h01;
			4'd4:    val = 8'h08;
			4'd5:    val = 8'h00;
			4'd6:    val = 8'h06;
			4'd7:    val = 8'h04;
			4'd8:    val = 8'h00;
			4'd9:    val = 8'h02;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/arprp_parse.sv
// Frame parser: byte position counter, header checks and sender address capture.
`default_nettype none
module arprp_parse
	import arprp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte_s1,
	input  wire logic       frame_end_s1,
	output result_t         res
);

	logic [PosW-1:0] pos_q, pos_nx;
	status_t         err_q, err_nx;
	logic [47:0]     mac_q, mac_nx;
	logic [31:0]     ip_q, ip_nx;
	logic [3:0]      hdr_idx;

	assign hdr_idx = pos_q[3:0] - POS_HDR_START[3:0];

	always_comb begin
		err_nx = err_q;
		mac_nx = mac_q;
		ip_nx  = ip_q;
		if (pos_q >= POS_HDR_START && pos_q < POS_ARP_END) begin
			if (rx_byte_s1 != expect_byte(hdr_idx) && err_q == ST_LEARNED) begin
				err_nx = (pos_q < POS_ETH_END) ? ST_NOT_ARP : ST_MISMATCH;
			end
		end else if (pos_q >= POS_ARP_END && pos_q < POS_MAC_END) begin
			mac_nx = {mac_q[39:0], rx_byte_s1};
		end else if (pos_q >= POS_MAC_END && pos_q < POS_LIMIT) begin
			ip_nx = {ip_q[23:0], rx_byte_s1};
		end
		pos_nx = (pos_q < POS_LIMIT) ? pos_q + PosW'(1) : pos_q;
	end

	always_comb begin
		if (pos_nx < POS_ETH_END)
			res.status = ST_RUNT;
		else if (err_nx == ST_NOT_ARP)
			res.status = ST_NOT_ARP;
		else if (pos_nx < POS_ARP_END)
			res.status = ST_SHORT;
		else if (err_nx == ST_MISMATCH)
			res.status = ST_MISMATCH;
		else if (pos_nx < POS_LIMIT)
			res.status = ST_TRUNC;
		else
			res.status = ST_LEARNED;
		res.mac = (res.status == ST_LEARNED) ? mac_nx : 48'd0;
		res.ip  = (res.status == ST_LEARNED) ? ip_nx : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= ST_LEARNED;
		end else if (step) begin
			pos_q <= frame_end_s1 ? '0 : pos_nx;
			err_q <= frame_end_s1 ? ST_LEARNED : err_nx;
		end
	end

	// captures are fully rewritten before any learned result, so no clear needed
	always_ff @(posedge clk) begin
		if (step) begin
			mac_q <= mac_nx;
			ip_q  <= ip_nx;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/arprp_outreg.sv
// Result register: holds one result transaction until the receiver takes it.
`default_nettype none
module arprp_outreg
	import arprp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire result_t     res,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             busy,
	output status_t          frame_status,
	output logic [47:0]      learned_mac,
	output logic [31:0]      learned_ip
);

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign busy         = valid_q && res_stall;
	assign res_valid    = valid_q;
	assign frame_status = data_q.status;
	assign learned_mac  = data_q.mac;
	assign learned_ip   = data_q.ip;

endmodule
`default_nettype wire

FILE: rtl/arp_reply_parser_top.sv
// Top level of the ARP reply parser: input register, parser and result register.
//
// Usage:
//   Input channel rx_valid/rx_stall carries one frame byte per transaction
//   (rx_byte, wire order) with frame_end high on the last byte of a frame.
//   Output channel res_valid/res_stall carries one result per frame:
//   frame_status and, when the status is learned (0), the sender MAC and
//   IPv4 address, first wire byte most significant; otherwise both are 0.
//   Throughput: one byte per cycle while rx_stall stays low.
//   A frame's last byte passes the input register, then the result register,
//   before its result is presented.
//   Reset clears the byte counter, error flag and all valid flags; the
//   first byte after reset starts a new frame.
//   While res_stall holds a pending result, bytes not ending a frame keep
//   flowing; a byte ending the next frame waits in the input register and
//   rx_stall rises until the pending result is taken.
`default_nettype none
module arp_reply_parser_top
	import arprp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_end,
	output logic             res_valid,
	input  wire logic        res_stall,
	output status_t          frame_status,
	output logic [47:0]      learned_mac,
	output logic [31:0]      learned_ip
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       frame_end_s1;
	logic       step;
	logic       busy;
	result_t    res;

	assign step     = valid_s1 && !(frame_end_s1 && busy);
	assign rx_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			rx_byte_s1   <= rx_byte;
			frame_end_s1 <= frame_end;
		end
	end

	arprp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte_s1   (rx_byte_s1),
		.frame_end_s1 (frame_end_s1),
		.res          (res)
	);

	arprp_outreg u_outreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step && frame_end_s1),
		.res          (res),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.busy         (busy),
		.frame_status (frame_status),
		.learned_mac  (learned_mac),
		.learned_ip   (learned_ip)
	);

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for arp_reply_parser_top: frame byte driver, result monitor and frame status predictor.
`default_nettype none
module tb_top;
	import arprp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RAND_BYTES   = 1000;
	localparam int RAND_FRAMES  = 60;
	localparam logic [79:0] ARP_REPLY_HDR = 80'h0806_0001_0800_0604_0002;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_item_t;

	logic        clk;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_stall;
	logic [7:0]  rx_byte;
	logic        frame_end;
	logic        res_valid;
	logic        res_stall;
	status_t     frame_status;
	logic [47:0] learned_mac;
	logic [31:0] learned_ip;

	arp_reply_parser_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.frame_end    (frame_end),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.frame_status (frame_status),
		.learned_mac  (learned_mac),
		.learned_ip   (learned_ip)
	);

	rx_item_t frame_bytes[$];
	result_t  arp_results_due[$];

	int       bytes_queued;
	int       frames_queued;
	int       bytes_sent;
	int       err_cnt;
	int       status_seen[6];
	int       cycle_cnt;

	// predictor state
	logic [5:0]  rx_pos;
	status_t     seen_err;
	logic [47:0] mac_sr;
	logic [31:0] ip_sr;

	logic rx_took;
	logic res_took;
	bit   rx_burst;
	bit   res_burst;
	int   rx_wait;
	int   res_wait;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	// bad_mask bit 9-i corrupts header byte 12+i; garbage makes every byte random
	task automatic queue_frame(input int len, input logic [9:0] bad_mask,
			input logic [47:0] mac, input logic [31:0] ip, input bit garbage);
		rx_item_t item;
		logic [7:0] b;
		for (int p = 0; p < len; p++) begin
			b = 8'($urandom_range(0, 255));
			if (!garbage) begin
				if (p >= 12 && p < 22) begin
					b = ARP_REPLY_HDR[79 - 8*(p-12) -: 8];
					if (bad_mask[9 - (p-12)])
						b = b ^ 8'($urandom_range(1, 255));
				end else if (p >= 22 && p < 28) begin
					b = mac[47 - 8*(p-22) -: 8];
				end else if (p >= 28 && p < 32) begin
					b = ip[31 - 8*(p-28) -: 8];
				end
			end
			item.data = b;
			item.last = (p == len - 1);
			frame_bytes.push_back(item);
		end
		bytes_queued += len;
		frames_queued++;
	endtask

	task automatic parse_arp_byte(input logic [7:0] data, input logic last);
		int idx;
		status_t st;
		result_t res;
		if (rx_pos >= POS_HDR_START && rx_pos < POS_ARP_END) begin
			idx = int'(rx_pos - POS_HDR_START);
			// ST_LEARNED doubles as "no error seen yet"
			if (data != ARP_REPLY_HDR[79 - 8*idx -: 8] && seen_err == ST_LEARNED)
				seen_err = (rx_pos < POS_ETH_END) ? ST_NOT_ARP : ST_MISMATCH;
		end else if (rx_pos >= POS_ARP_END && rx_pos < POS_MAC_END) begin
			mac_sr = {mac_sr[39:0], data};
		end else if (rx_pos >= POS_MAC_END && rx_pos < POS_LIMIT) begin
			ip_sr = {ip_sr[23:0], data};
		end
		if (rx_pos < POS_LIMIT)
			rx_pos = rx_pos + 6'd1;
		if (last) begin
			if (rx_pos < POS_ETH_END)
				st = ST_RUNT;
			else if (seen_err == ST_NOT_ARP)
				st = ST_NOT_ARP;
			else if (rx_pos < POS_ARP_END)
				st = ST_SHORT;
			else if (seen_err == ST_MISMATCH)
				st = ST_MISMATCH;
			else if (rx_pos < POS_LIMIT)
				st = ST_TRUNC;
			else
				st = ST_LEARNED;
			res.status = st;
			res.mac    = (st == ST_LEARNED) ? mac_sr : 48'd0;
			res.ip     = (st == ST_LEARNED) ? ip_sr : 32'd0;
			arp_results_due.push_back(res);
			rx_pos   = '0;
			seen_err = ST_LEARNED;
			mac_sr   = '0;
			ip_sr    = '0;
		end
	endtask

	task automatic check_result();
		result_t exp_res;
		if (arp_results_due.size() == 0) begin
			$display("%0t: unexpected result status=%0d mac=%012h ip=%08h",
				$time, frame_status, learned_mac, learned_ip);
			err_cnt++;
		end else begin
			exp_res = arp_results_due.pop_front();
			if (frame_status != exp_res.status) begin
				$display("%0t: frame_status expected %0d actual %0d",
					$time, exp_res.status, frame_status);
				err_cnt++;
			end
			if (learned_mac != exp_res.mac) begin
				$display("%0t: learned_mac expected %012h actual %012h",
					$time, exp_res.mac, learned_mac);
				err_cnt++;
			end
			if (learned_ip != exp_res.ip) begin
				$display("%0t: learned_ip expected %08h actual %08h",
					$time, exp_res.ip, learned_ip);
				err_cnt++;
			end
		end
		if (frame_status <= ST_TRUNC)
			status_seen[frame_status]++;
	endtask

	// monitor and predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_took  <= 1'b0;
			res_took <= 1'b0;
			rx_pos   = '0;
			seen_err = ST_LEARNED;
			mac_sr   = '0;
			ip_sr    = '0;
		end else begin
			rx_took  <= rx_valid && !rx_stall;
			res_took <= res_valid && !res_stall;
			if (rx_valid && !rx_stall)
				parse_arp_byte(rx_byte, frame_end);
			if (res_valid && !res_stall)
				check_result();
		end
	end

	// byte driver
	always @(negedge clk) begin : drive_rx
		logic nxt_valid;
		rx_item_t item;
		nxt_valid = rx_valid;
		if (arst_n) begin
			if (rx_valid && rx_took) begin
				nxt_valid = 1'b0;
				bytes_sent++;
			end
			if (!nxt_valid) begin
				if (rx_wait > 0) begin
					rx_wait--;
				end else if (frame_bytes.size() > 0) begin
					item = frame_bytes.pop_front();
					rx_byte   <= item.data;
					frame_end <= item.last;
					nxt_valid = 1'b1;
					if ($urandom_range(0, 24) == 0)
						rx_burst = !rx_burst;
					rx_wait = draw_wait(rx_burst);
				end
			end
		end
		rx_valid <= nxt_valid;
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_took) begin
				if ($urandom_range(0, 7) == 0)
					res_burst = !res_burst;
				res_wait = draw_wait(res_burst);
			end
			res_stall <= (res_wait > 0);
			if (res_valid && res_wait > 0)
				res_wait--;
		end
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int kind;
		int len;
		logic [9:0] bad;
		logic [47:0] mac;
		logic [31:0] ip;

		arst_n    = 1'b0;
		rx_valid  = 1'b0;
		rx_byte   = 8'd0;
		frame_end = 1'b0;
		res_stall = 1'b0;
		rx_wait   = 0;
		res_wait  = 0;
		rx_burst  = 1'b0;
		res_burst = 1'b0;
		bytes_queued  = 0;
		frames_queued = 0;
		bytes_sent    = 0;
		err_cnt       = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;

		// directed frames
		queue_frame(1, '0, '0, '0, 1'b0);                     // runt, single byte
		queue_frame(13, '0, '0, '0, 1'b0);                    // longest runt
		queue_frame(14, 10'b10_0000_0000, '0, '0, 1'b0);      // bad EtherType high byte
		queue_frame(40, 10'b01_0000_0001, '1, '1, 1'b0);      // bad EtherType beats mismatch
		queue_frame(14, '0, '0, '0, 1'b0);                    // header short, clean
		queue_frame(21, 10'b00_0100_0000, '0, '0, 1'b0);      // short beats mismatch
		for (int i = 2; i < 10; i++)                          // each ARP header byte wrong
			queue_frame(22 + i, 10'b10_0000_0000 >> i, 48'h0123_4567_89ab,
				32'hc0a8_0001, 1'b0);
		queue_frame(22, '0, '0, '0, 1'b0);                    // sender truncated, no sender
		queue_frame(31, '0, '1, '1, 1'b0);                    // sender truncated, one short
		queue_frame(32, '0, '0, '0, 1'b0);                    // learned, all zero
		queue_frame(32, '0, '1, '1, 1'b0);                    // learned, all ones
		queue_frame(100, '0, 48'hfedc_ba98_7654, 32'h0a00_00ff, 1'b0); // long frame

		// random frames, mostly well-formed replies
		while (bytes_queued < RAND_BYTES || frames_queued < RAND_FRAMES) begin
			kind = $urandom_range(0, 99);
			mac  = 48'({$urandom(), $urandom()});
			ip   = $urandom();
			if ($urandom_range(0, 9) == 0)
				mac = ($urandom_range(0, 1) != 0) ? '1 : '0;
			if ($urandom_range(0, 9) == 0)
				ip = ($urandom_range(0, 1) != 0) ? '1 : '0;
			bad = '0;
			if (kind < 65) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 80) : 32;
			end else if (kind < 75) begin
				len = $urandom_range(22, 31);
			end else if (kind < 87) begin
				len = $urandom_range(12, 64);
				bad = 10'b10_0000_0000 >> $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0)
					bad = bad | 10'($urandom_range(0, 1023));
			end else if (kind < 94) begin
				len = $urandom_range(1, 13);
			end else begin
				len = $urandom_range(1, 64);
			end
			queue_frame(len, bad, mac, ip, kind >= 94);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (bytes_sent < bytes_queued || arp_results_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d frames of %0d bytes with random gaps and result stalls.",
			frames_queued, bytes_queued);
		$display("Results: learned %0d, runt %0d, not ARP %0d, short %0d, mismatch %0d, trunc %0d",
			status_seen[ST_LEARNED], status_seen[ST_RUNT], status_seen[ST_NOT_ARP],
			status_seen[ST_SHORT], status_seen[ST_MISMATCH], status_seen[ST_TRUNC]);
		if (err_cnt == 0 && arp_results_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
